/* rtl/assert_macros.svh */
// assertion macros used by the parser rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ON_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define ASSERT_NEXT_CLK(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_ON_CLK(label, clk, rst, prop)
`define ASSERT_NEXT_CLK(label, clk, rst, ante, cons)
`endif
`endif

/* rtl/rlbp_pkg.sv */
// types, constants and helpers for the range list to bitmap parser
package rlbp_pkg;

   localparam int VECTOR_COUNT_DEF = 256;

   localparam int CHAR_W   = 8;
   localparam int QIDX_W   = 10;
   localparam int STATUS_W = 2;

   localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_DASH  = 8'h2d;
   localparam logic [CHAR_W-1:0] CHAR_COMMA = 8'h2c;

   localparam int RADIX = 10;

   localparam logic CMD_CHAR  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_PARSING = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_DONE    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_ERROR   = 2'd2;

   typedef enum logic [2:0] {
      PH_START_FIRST,
      PH_IN_START,
      PH_END_FIRST,
      PH_IN_END,
      PH_DONE,
      PH_ERROR
   } phase_type;

   // command from the parser to the bitmap
   typedef struct packed {
      logic set;
      logic clear;
   } bm_ctrl_type;

   function automatic logic [STATUS_W-1:0] status_of(input phase_type ph);
      logic [STATUS_W-1:0] st;
      case (ph)
         PH_DONE:  st = STATUS_DONE;
         PH_ERROR: st = STATUS_ERROR;
         default:  st = STATUS_PARSING;
      endcase
      return st;
   endfunction

endpackage

/* rtl/rlbp_bitmap.sv */
// enable bitmap with parallel range set, full clear and single bit read
module rlbp_bitmap #(
   parameter int VECTOR_COUNT = rlbp_pkg::VECTOR_COUNT_DEF,
   localparam int IDX_W = $clog2(VECTOR_COUNT)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  rlbp_pkg::bm_ctrl_type     ctrl,
   input  logic [IDX_W-1:0]          set_lo,
   input  logic [IDX_W-1:0]          set_hi,
   input  logic [rlbp_pkg::QIDX_W-1:0] query_index,
   output logic                      query_bit
);

   localparam int CMP_W = rlbp_pkg::QIDX_W + 1;

   logic [VECTOR_COUNT-1:0] bits_ff;
   logic [VECTOR_COUNT-1:0] bits_in;
   logic                    in_range;

   always_comb begin
      bits_in = bits_ff;
      if (ctrl.clear) begin
         bits_in = '0;
      end else if (ctrl.set) begin
         for (int i = 0; i < VECTOR_COUNT; i++) begin
            if (IDX_W'(i) >= set_lo && IDX_W'(i) <= set_hi) begin
               bits_in[i] = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bits_ff <= '0;
      end else begin
         bits_ff <= bits_in;
      end
   end

   assign in_range  = CMP_W'(query_index) < CMP_W'(VECTOR_COUNT);
   assign query_bit = in_range ? bits_ff[query_index[IDX_W-1:0]] : 1'b0;

endmodule

/* rtl/range_list_to_bitmap_parser.sv */
// Decimal range list parser ("3,5-9,12", zero byte ends it) that builds an enable bitmap of
// VECTOR_COUNT bits and answers bit queries. Each transaction is one character or one query;
// a new transaction is taken every cycle while results are taken, and its result is presented
// from the result register after it has passed the input register. While rsp_ready is low,
// the held result and one waiting transaction fill both registers and req_ready drops. A
// finished range is written into the bitmap at once by a compare of every bitmap index
// against the range bounds, so the width of that compare array grows with VECTOR_COUNT. Reset
// clears the bitmap flip-flops directly, with no clearing pass. After the list finishes or
// fails, characters are ignored until reset.
`include "assert_macros.svh"

module range_list_to_bitmap_parser #(
   parameter int VECTOR_COUNT = rlbp_pkg::VECTOR_COUNT_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_cmd,
   input  logic [rlbp_pkg::CHAR_W-1:0]   req_list_char,
   input  logic [rlbp_pkg::QIDX_W-1:0]   req_query_index,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [rlbp_pkg::STATUS_W-1:0] rsp_parse_status,
   output logic                          rsp_bit_enabled
);

   localparam int IDX_W = $clog2(VECTOR_COUNT);
   localparam int ACC_W = $clog2(VECTOR_COUNT + 1);
   localparam int SUM_W = ACC_W + 4;
   localparam logic [ACC_W-1:0] ACC_MAX = ACC_W'(VECTOR_COUNT);

   // input register
   logic                        s1_valid_ff;
   logic                        s1_cmd_ff;
   logic [rlbp_pkg::CHAR_W-1:0] s1_char_ff;
   logic [rlbp_pkg::QIDX_W-1:0] s1_idx_ff;

   // result register
   logic                          rsp_valid_ff;
   logic [rlbp_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [rlbp_pkg::STATUS_W-1:0] rsp_status_in;
   logic                          rsp_bit_ff;
   logic                          rsp_bit_in;

   // parser state
   rlbp_pkg::phase_type phase_ff;
   rlbp_pkg::phase_type phase_in;
   logic [ACC_W-1:0]    acc_ff;
   logic [ACC_W-1:0]    acc_in;
   logic [IDX_W-1:0]    start_ff;
   logic [IDX_W-1:0]    start_in;

   logic                  adv;
   logic                  take_char;
   logic                  is_digit;
   logic [3:0]            digit_val;
   logic                  acc_restart;
   logic [ACC_W-1:0]      acc_base;
   logic [SUM_W-1:0]      acc_sum;
   logic [ACC_W-1:0]      acc_sat;
   rlbp_pkg::bm_ctrl_type bm_ctrl;
   logic [IDX_W-1:0]      set_lo;
   logic [IDX_W-1:0]      set_hi;
   logic                  query_bit;

   assign adv       = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || adv;
   assign take_char = adv && (s1_cmd_ff == rlbp_pkg::CMD_CHAR);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_cmd_ff  <= req_cmd;
         s1_char_ff <= req_list_char;
         s1_idx_ff  <= req_query_index;
      end
   end

   // decimal accumulate with saturation at the vector count
   assign is_digit    = s1_char_ff inside {[rlbp_pkg::CHAR_ZERO:rlbp_pkg::CHAR_NINE]};
   assign digit_val   = 4'(s1_char_ff - rlbp_pkg::CHAR_ZERO);
   assign acc_restart = (phase_ff == rlbp_pkg::PH_START_FIRST) ||
                        (phase_ff == rlbp_pkg::PH_END_FIRST);
   assign acc_base    = acc_restart ? '0 : acc_ff;
   assign acc_sum     = SUM_W'(acc_base) * SUM_W'(rlbp_pkg::RADIX) + SUM_W'(digit_val);
   assign acc_sat     = (acc_sum > SUM_W'(VECTOR_COUNT)) ? ACC_MAX : ACC_W'(acc_sum);

   always_comb begin
      phase_in = phase_ff;
      acc_in   = acc_ff;
      start_in = start_ff;
      bm_ctrl  = '{set: 1'b0, clear: 1'b0};
      set_lo   = IDX_W'(acc_ff);
      set_hi   = IDX_W'(acc_ff);
      if (take_char) begin
         case (phase_ff)
            rlbp_pkg::PH_START_FIRST, rlbp_pkg::PH_END_FIRST: begin
               if (s1_char_ff == rlbp_pkg::CHAR_NUL &&
                   phase_ff == rlbp_pkg::PH_START_FIRST) begin
                  phase_in = rlbp_pkg::PH_DONE;
               end else if (is_digit) begin
                  acc_in   = acc_sat;
                  phase_in = (phase_ff == rlbp_pkg::PH_START_FIRST) ?
                             rlbp_pkg::PH_IN_START : rlbp_pkg::PH_IN_END;
               end else begin
                  phase_in      = rlbp_pkg::PH_ERROR;
                  bm_ctrl.clear = 1'b1;
               end
            end
            rlbp_pkg::PH_IN_START, rlbp_pkg::PH_IN_END: begin
               if (is_digit) begin
                  acc_in = acc_sat;
               end else if (acc_ff >= ACC_MAX ||
                            (phase_ff == rlbp_pkg::PH_IN_END &&
                             acc_ff < ACC_W'(start_ff))) begin
                  phase_in      = rlbp_pkg::PH_ERROR;
                  bm_ctrl.clear = 1'b1;
               end else if (phase_ff == rlbp_pkg::PH_IN_START &&
                            s1_char_ff == rlbp_pkg::CHAR_DASH) begin
                  start_in = IDX_W'(acc_ff);
                  acc_in   = '0;
                  phase_in = rlbp_pkg::PH_END_FIRST;
               end else begin
                  // entry complete: mark it if the separator is a comma or the terminator, else fail
                  if (phase_ff == rlbp_pkg::PH_IN_END) begin
                     set_lo = start_ff;
                  end
                  if (s1_char_ff == rlbp_pkg::CHAR_COMMA) begin
                     bm_ctrl.set = 1'b1;
                     acc_in      = '0;
                     phase_in    = rlbp_pkg::PH_START_FIRST;
                  end else if (s1_char_ff == rlbp_pkg::CHAR_NUL) begin
                     bm_ctrl.set = 1'b1;
                     phase_in    = rlbp_pkg::PH_DONE;
                  end else begin
                     phase_in      = rlbp_pkg::PH_ERROR;
                     bm_ctrl.clear = 1'b1;
                  end
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= rlbp_pkg::PH_START_FIRST;
         acc_ff   <= '0;
         start_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         start_ff <= start_in;
      end
   end

   rlbp_bitmap #(
      .VECTOR_COUNT(VECTOR_COUNT)
   ) u_bitmap (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (bm_ctrl),
      .set_lo     (set_lo),
      .set_hi     (set_hi),
      .query_index(s1_idx_ff),
      .query_bit  (query_bit)
   );

   assign rsp_status_in = rlbp_pkg::status_of(phase_in);
   assign rsp_bit_in    = (s1_cmd_ff == rlbp_pkg::CMD_QUERY) && query_bit;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_status_ff <= rsp_status_in;
         rsp_bit_ff    <= rsp_bit_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_parse_status = rsp_status_ff;
   assign rsp_bit_enabled  = rsp_bit_ff;

   // an error is final until reset
   `ASSERT_NEXT_CLK(a_error_sticks, clock, reset, phase_ff == rlbp_pkg::PH_ERROR, phase_ff == rlbp_pkg::PH_ERROR)
   // the bitmap is empty once parsing has failed
   `ASSERT_ON_CLK(a_error_empty, clock, reset, (rsp_valid_ff && rsp_status_ff == rlbp_pkg::STATUS_ERROR) |-> !rsp_bit_ff)
   // accumulator saturates at the vector count
   `ASSERT_ON_CLK(a_acc_sat, clock, reset, acc_ff <= ACC_MAX)
   // input side stalls only when both registers hold a transaction
   `ASSERT_ON_CLK(a_stall_full, clock, reset, !req_ready |-> (s1_valid_ff && rsp_valid_ff))

endmodule

/* sim/tb.sv */
// testbench for range_list_to_bitmap_parser: list and query traffic checked against a predictor
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int VC          = rlbp_pkg::VECTOR_COUNT_DEF;
   localparam int ITEM_TARGET = 380;
   localparam int STALL_LIMIT = 1000;
   localparam int DRAIN_WAIT  = 8;

   typedef logic [rlbp_pkg::CHAR_W-1:0]   char_type;
   typedef logic [rlbp_pkg::QIDX_W-1:0]   qidx_type;
   typedef logic [rlbp_pkg::STATUS_W-1:0] status_type;

   typedef enum int {
      END_EMPTY,
      END_CLEAN,
      END_TRAILING_COMMA,
      END_MISSING_DIGIT,
      END_TOO_LARGE,
      END_REVERSED,
      END_BAD_SEP_START,
      END_BAD_SEP_END
   } list_ending_type;

   // predicts status and bitmap readback for each transaction, checks the responses
   class bitmap_scoreboard;
      typedef struct {
         status_type status;
         logic       bit_on;
      } outcome_type;

      rlbp_pkg::phase_type phase;
      int unsigned         accum;
      int unsigned         range_lo;
      bit [VC-1:0]         enabled;
      outcome_type         outcome_due[$];
      int                  mismatches;

      function new();
         phase      = rlbp_pkg::PH_START_FIRST;
         accum      = 0;
         range_lo   = 0;
         enabled    = '0;
         mismatches = 0;
      endfunction

      function bit is_digit(char_type c);
         return c >= rlbp_pkg::CHAR_ZERO && c <= rlbp_pkg::CHAR_NINE;
      endfunction

      function void abort_list();
         enabled = '0;
         phase   = rlbp_pkg::PH_ERROR;
      endfunction

      function void add_digit(char_type c);
         int unsigned v;
         v     = accum * rlbp_pkg::RADIX + (c - rlbp_pkg::CHAR_ZERO);
         accum = (v > VC) ? VC : v;
      endfunction

      function void mark_span(int unsigned lo, int unsigned hi);
         for (int unsigned i = lo; i <= hi && i < VC; i++) enabled[i] = 1'b1;
      endfunction

      function void close_entry(char_type c);
         if (c == rlbp_pkg::CHAR_COMMA) begin
            phase = rlbp_pkg::PH_START_FIRST;
            accum = 0;
         end else if (c == rlbp_pkg::CHAR_NUL) begin
            phase = rlbp_pkg::PH_DONE;
         end else begin
            abort_list();
         end
      endfunction

      function void parse_char(char_type c);
         case (phase)
            rlbp_pkg::PH_START_FIRST: begin
               if (c == rlbp_pkg::CHAR_NUL) begin
                  phase = rlbp_pkg::PH_DONE;
               end else if (is_digit(c)) begin
                  accum = 0;
                  add_digit(c);
                  phase = rlbp_pkg::PH_IN_START;
               end else begin
                  abort_list();
               end
            end
            rlbp_pkg::PH_IN_START: begin
               if (is_digit(c)) begin
                  add_digit(c);
               end else if (accum >= VC) begin
                  abort_list();
               end else if (c == rlbp_pkg::CHAR_DASH) begin
                  range_lo = accum;
                  accum    = 0;
                  phase    = rlbp_pkg::PH_END_FIRST;
               end else begin
                  mark_span(accum, accum);
                  close_entry(c);
               end
            end
            rlbp_pkg::PH_END_FIRST: begin
               if (is_digit(c)) begin
                  accum = 0;
                  add_digit(c);
                  phase = rlbp_pkg::PH_IN_END;
               end else begin
                  abort_list();
               end
            end
            rlbp_pkg::PH_IN_END: begin
               if (is_digit(c)) begin
                  add_digit(c);
               end else if (accum >= VC || accum < range_lo) begin
                  abort_list();
               end else begin
                  mark_span(range_lo, accum);
                  close_entry(c);
               end
            end
            default: ;
         endcase
      endfunction

      function void take_request(logic cmd, char_type ch, qidx_type idx);
         outcome_type o;
         o.bit_on = 1'b0;
         if (cmd == rlbp_pkg::CMD_CHAR) parse_char(ch);
         else if (idx < VC) o.bit_on = enabled[idx];
         if (phase == rlbp_pkg::PH_DONE) o.status = rlbp_pkg::STATUS_DONE;
         else if (phase == rlbp_pkg::PH_ERROR) o.status = rlbp_pkg::STATUS_ERROR;
         else o.status = rlbp_pkg::STATUS_PARSING;
         outcome_due.push_back(o);
      endfunction

      task report(string msg);
         mismatches++;
         $display("%0t mismatch: %s", $realtime, msg);
      endtask

      task check_response(status_type status, logic bit_on);
         outcome_type o;
         if (outcome_due.size() == 0) begin
            report($sformatf("response with nothing outstanding (status %0d bit %0b)",
                             status, bit_on));
         end else begin
            o = outcome_due.pop_front();
            if (status !== o.status)
               report($sformatf("parse_status %0d, expected %0d", status, o.status));
            if (bit_on !== o.bit_on)
               report($sformatf("bit_enabled %0b, expected %0b", bit_on, o.bit_on));
         end
      endtask

      function int pending();
         return outcome_due.size();
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic       req_cmd;
   char_type   req_list_char;
   qidx_type   req_query_index;
   logic       rsp_valid;
   logic       rsp_ready;
   status_type rsp_parse_status;
   logic       rsp_bit_enabled;

   bitmap_scoreboard sb = new();
   int               stalled_cycles = 0;
   int               items_sent = 0;
   bit               no_idle = 1'b0;

   range_list_to_bitmap_parser DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_list_char   (req_list_char),
      .req_query_index (req_query_index),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_parse_status(rsp_parse_status),
      .rsp_bit_enabled (rsp_bit_enabled)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic qidx_type pick_index();
      if ($urandom_range(0, 4) == 0) return qidx_type'($urandom_range(0, 1023));
      return qidx_type'($urandom_range(0, VC - 1));
   endfunction

   // any character that is neither a digit, a separator nor the terminator
   function automatic char_type pick_bad_char();
      char_type c;
      do begin
         c = char_type'($urandom_range(1, 255));
      end while ((c >= rlbp_pkg::CHAR_ZERO && c <= rlbp_pkg::CHAR_NINE) ||
                 c == rlbp_pkg::CHAR_COMMA || c == rlbp_pkg::CHAR_DASH);
      return c;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         stalled_cycles <= 0;
      end else begin
         if (req_valid && req_ready) sb.take_request(req_cmd, req_list_char, req_query_index);
         if (rsp_valid && rsp_ready) sb.check_response(rsp_parse_status, rsp_bit_enabled);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) stalled_cycles <= 0;
         else stalled_cycles <= stalled_cycles + 1;
      end
   end

   initial begin
      wait (stalled_cycles >= STALL_LIMIT);
      $display("FAIL range_list_to_bitmap_parser");
      $finish;
   end

   // response side back-pressure
   initial begin : rsp_side
      int hold;
      hold = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold != 0) begin
            hold--;
         end else if (no_idle || $urandom_range(0, 1) == 1) begin
            rsp_ready <= 1'b1;
            hold = no_idle ? 0 : $urandom_range(0, 6);
         end else begin
            rsp_ready <= 1'b0;
            hold = pick_gap();
         end
      end
   end

   task automatic send_item(input logic cmd, input char_type ch, input qidx_type idx);
      int gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_cmd         <= cmd;
      req_list_char   <= ch;
      req_query_index <= idx;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic send_char(input char_type c);
      send_item(rlbp_pkg::CMD_CHAR, c, qidx_type'($urandom_range(0, 1023)));
   endtask

   task automatic send_query(input qidx_type idx);
      send_item(rlbp_pkg::CMD_QUERY, char_type'($urandom_range(0, 255)), idx);
   endtask

   task automatic maybe_query();
      if ($urandom_range(0, 5) == 0) send_query(pick_index());
   endtask

   task automatic send_number(input int unsigned v);
      string s;
      int    pad;
      s   = $sformatf("%0d", v);
      pad = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0;
      repeat (pad) send_char(rlbp_pkg::CHAR_ZERO);
      for (int i = 0; i < s.len(); i++) begin
         send_char(s[i]);
         maybe_query();
      end
   endtask

   task automatic send_entry();
      int unsigned lo, room, w;
      if ($urandom_range(0, 4) < 3) begin
         send_number($urandom_range(0, VC - 1));
      end else begin
         lo   = $urandom_range(0, VC - 1);
         room = VC - 1 - lo;
         if ($urandom_range(0, 9) == 0) w = $urandom_range(0, room);
         else w = $urandom_range(0, (room < 7) ? room : 7);
         send_number(lo);
         send_char(rlbp_pkg::CHAR_DASH);
         send_number(lo + w);
      end
      maybe_query();
   endtask

   // separator for a broken tail: anything at all
   task automatic send_any_sep();
      case ($urandom_range(0, 3))
         0: send_char(rlbp_pkg::CHAR_COMMA);
         1: send_char(rlbp_pkg::CHAR_DASH);
         2: send_char(rlbp_pkg::CHAR_NUL);
         default: send_char(pick_bad_char());
      endcase
   endtask

   task automatic send_ending(input list_ending_type ending);
      int unsigned hi;
      case (ending)
         END_CLEAN: send_char(rlbp_pkg::CHAR_NUL);
         END_TRAILING_COMMA: begin
            send_char(rlbp_pkg::CHAR_COMMA);
            send_char(rlbp_pkg::CHAR_NUL);
         end
         END_MISSING_DIGIT: begin
            send_char(rlbp_pkg::CHAR_COMMA);
            if ($urandom_range(0, 1) == 0) begin
               send_any_sep();
            end else begin
               send_number($urandom_range(0, VC - 1));
               send_char(rlbp_pkg::CHAR_DASH);
               send_any_sep();
            end
         end
         END_TOO_LARGE: begin
            send_char(rlbp_pkg::CHAR_COMMA);
            if ($urandom_range(0, 1) == 0) begin
               send_number($urandom_range(0, 1) ? VC : $urandom_range(VC, 99999));
            end else begin
               send_number($urandom_range(0, VC - 1));
               send_char(rlbp_pkg::CHAR_DASH);
               send_number($urandom_range(VC, 99999));
            end
            send_any_sep();
         end
         END_REVERSED: begin
            hi = $urandom_range(1, VC - 1);
            send_char(rlbp_pkg::CHAR_COMMA);
            send_number(hi);
            send_char(rlbp_pkg::CHAR_DASH);
            send_number($urandom_range(0, hi - 1));
            send_char($urandom_range(0, 1) ? rlbp_pkg::CHAR_COMMA : rlbp_pkg::CHAR_NUL);
         end
         END_BAD_SEP_START: begin
            send_char(rlbp_pkg::CHAR_COMMA);
            send_number($urandom_range(0, VC - 1));
            send_char(pick_bad_char());
         end
         END_BAD_SEP_END: begin
            hi = $urandom_range(0, VC - 1);
            send_char(rlbp_pkg::CHAR_COMMA);
            send_number($urandom_range(0, hi));
            send_char(rlbp_pkg::CHAR_DASH);
            send_number(hi);
            send_char($urandom_range(0, 1) ? rlbp_pkg::CHAR_DASH : pick_bad_char());
         end
         default: send_char(rlbp_pkg::CHAR_NUL);
      endcase
   endtask

   initial begin : stimulus
      list_ending_type ending;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_cmd         = rlbp_pkg::CMD_CHAR;
      req_list_char   = rlbp_pkg::CHAR_NUL;
      req_query_index = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      ending = list_ending_type'($urandom_range(END_EMPTY, END_BAD_SEP_END));
      if (ending == END_EMPTY) send_char(rlbp_pkg::CHAR_NUL);

      // directed: empty bitmap, lowest and highest values, leading zeros, one-wide range
      send_query(10'd0);
      send_query(10'd1023);
      send_char("0");
      send_char(rlbp_pkg::CHAR_COMMA);
      send_char("0");
      send_char("0");
      send_char("2");
      send_char("5");
      send_char("5");
      send_char(rlbp_pkg::CHAR_COMMA);
      send_char("3");
      send_char("0");
      send_char(rlbp_pkg::CHAR_DASH);
      send_char("3");
      send_char("0");
      send_query(10'd0);
      send_query(qidx_type'(VC - 1));
      send_query(qidx_type'(VC));
      send_query(10'd30);
      send_query(10'd31);

      // hold off until the pipeline has drained
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);

      while (items_sent < ITEM_TARGET) begin
         if ($urandom_range(0, 19) == 0) no_idle = !no_idle;
         send_char(rlbp_pkg::CHAR_COMMA);
         send_entry();
      end
      no_idle = 1'b0;
      send_ending(ending);

      // finished or failed: characters are ignored, queries still read the bitmap
      send_char(8'hFF);
      send_char(rlbp_pkg::CHAR_NUL);
      repeat (40) begin
         if ($urandom_range(0, 1) == 0) send_query(pick_index());
         else send_char(char_type'($urandom_range(0, 255)));
      end
      req_valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (sb.mismatches == 0) $display("PASS range_list_to_bitmap_parser");
      else $display("FAIL range_list_to_bitmap_parser");
      $finish;
   end

endmodule
